// ===== rtl/line_rasterizer_macros.svh =====
// Assertion macros for line_rasterizer.sv, the file that carries concurrent checks.
`ifndef LINE_RASTERIZER_MACROS_SVH
`define LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LRAST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line_rasterizer check failed");

// Next-cycle implication, checked outside reset.
`define LRAST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line_rasterizer check failed");

`endif

// ===== rtl/lrast_pkg.sv =====
package lrast_pkg;

    // Default coordinate width.
    localparam int COORD_BITS_DEF = 12;

    // Fixed field widths.
    localparam int STRIDE_BITS = 13;
    localparam int ADDR_BITS   = 32;
    localparam int COLOR_BITS  = 8;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    // Command codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    // Register indexes (word address, paddr[2]).
    localparam logic REG_LINE_STRIDE = 1'b0;
    localparam logic REG_FRAME_BASE  = 1'b1;

    // Register reset values.
    localparam logic [STRIDE_BITS-1:0] LINE_STRIDE_RESET = 13'd720;
    localparam logic [ADDR_BITS-1:0]   FRAME_BASE_RESET  = 32'd0;

    typedef struct packed {
        logic [STRIDE_BITS-1:0] line_stride;
        logic [ADDR_BITS-1:0]   frame_base;
    } cfg_t;

endpackage

// ===== rtl/lrast_in_if.sv =====
interface lrast_in_if #(
    parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEF
) ();
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic [COORD_BITS-1:0]               x_start;
    logic [COORD_BITS-1:0]               y_start;
    logic [COORD_BITS-1:0]               x_end;
    logic [COORD_BITS-1:0]               y_end;
    logic [lrast_pkg::COLOR_BITS-1:0]    color;

    modport source (
        output valid, op, x_start, y_start, x_end, y_end, color,
        input  ready
    );

    modport sink (
        input  valid, op, x_start, y_start, x_end, y_end, color,
        output ready
    );
endinterface

// ===== rtl/lrast_out_if.sv =====
interface lrast_out_if #(
    parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEF
) ();
    logic                                valid;
    logic                                ready;
    logic [COORD_BITS-1:0]               pixel_x;
    logic [COORD_BITS-1:0]               pixel_y;
    logic [lrast_pkg::ADDR_BITS-1:0]     pixel_address;
    logic [lrast_pkg::COLOR_BITS-1:0]    pixel_color;
    logic                                last;

    modport source (
        output valid, pixel_x, pixel_y, pixel_address, pixel_color, last,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_address, pixel_color, last,
        output ready
    );
endinterface

// ===== rtl/lrast_cfg.sv =====
module lrast_cfg (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [lrast_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [lrast_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [lrast_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                   pready,
    output lrast_pkg::cfg_t                        cfg
);

    logic [lrast_pkg::STRIDE_BITS-1:0] line_stride_reg;
    logic [lrast_pkg::ADDR_BITS-1:0]   frame_base_reg;
    logic                              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_stride_reg <= lrast_pkg::LINE_STRIDE_RESET;
            frame_base_reg  <= lrast_pkg::FRAME_BASE_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                lrast_pkg::REG_LINE_STRIDE:
                    line_stride_reg <= pwdata[lrast_pkg::STRIDE_BITS-1:0];
                lrast_pkg::REG_FRAME_BASE:
                    frame_base_reg <= pwdata;
                default:
                    frame_base_reg <= frame_base_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            lrast_pkg::REG_LINE_STRIDE:
                prdata = {{(lrast_pkg::APB_DATA_BITS - lrast_pkg::STRIDE_BITS){1'b0}},
                          line_stride_reg};
            lrast_pkg::REG_FRAME_BASE:
                prdata = frame_base_reg;
            default:
                prdata = '0;
        endcase
    end

    assign cfg.line_stride = line_stride_reg;
    assign cfg.frame_base  = frame_base_reg;

endmodule

// ===== rtl/lrast_step.sv =====
module lrast_step #(
    parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    lrast_in_if.sink                           cmd,
    output logic                               stp_valid,
    input  logic                               stp_ready,
    output logic [COORD_BITS-1:0]              stp_x,
    output logic [COORD_BITS-1:0]              stp_y,
    output logic [lrast_pkg::COLOR_BITS-1:0]   stp_color,
    output logic                               stp_last
);

    localparam int DW = COORD_BITS + 3;
    localparam int IW = COORD_BITS + 2;

    // Input register.
    logic                              cmd_valid_reg;
    logic                              op_reg;
    logic [COORD_BITS-1:0]             xs_reg;
    logic [COORD_BITS-1:0]             ys_reg;
    logic [COORD_BITS-1:0]             xe_reg;
    logic [COORD_BITS-1:0]             ye_reg;
    logic [lrast_pkg::COLOR_BITS-1:0]  color_in_reg;

    // Line state.
    logic                              busy_reg;
    logic [COORD_BITS-1:0]             cur_x_reg;
    logic [COORD_BITS-1:0]             cur_y_reg;
    logic [COORD_BITS-1:0]             end_major_reg;
    logic [DW-1:0]                     decision_reg;
    logic [IW-1:0]                     inc_straight_reg;
    logic [DW-1:0]                     inc_diagonal_reg;
    logic                              minor_down_reg;
    logic                              x_major_reg;
    logic [lrast_pkg::COLOR_BITS-1:0]  held_color_reg;

    // Pixel register.
    logic                              pix_valid_reg;
    logic [COORD_BITS-1:0]             pix_x_reg;
    logic [COORD_BITS-1:0]             pix_y_reg;
    logic [lrast_pkg::COLOR_BITS-1:0]  pix_color_reg;
    logic                              pix_last_reg;

    // Next values.
    logic [COORD_BITS-1:0]             dx;
    logic [COORD_BITS-1:0]             dy;
    logic [COORD_BITS-1:0]             dmaj;
    logic [COORD_BITS-1:0]             dmin;
    logic [COORD_BITS-1:0]             sa;
    logic [COORD_BITS-1:0]             sb;
    logic                              xmaj_s;
    logic                              diag;
    logic [COORD_BITS-1:0]             minor_add;
    logic [COORD_BITS-1:0]             cur_x_next;
    logic [COORD_BITS-1:0]             cur_y_next;
    logic [COORD_BITS-1:0]             end_major_next;
    logic [DW-1:0]                     decision_next;
    logic [IW-1:0]                     inc_straight_next;
    logic [DW-1:0]                     inc_diagonal_next;
    logic                              minor_down_next;
    logic                              x_major_next;
    logic [lrast_pkg::COLOR_BITS-1:0]  held_color_next;
    logic [COORD_BITS-1:0]             major_next;
    logic                              fin_next;
    logic                              has_result;
    logic                              pix_room;
    logic                              step_go;

    assign pix_room  = !pix_valid_reg || stp_ready;
    assign step_go   = cmd_valid_reg && pix_room;
    assign cmd.ready = !cmd_valid_reg || pix_room;

    always_comb
    begin
        // Setup terms for a new line.
        dx     = (xs_reg > xe_reg) ? (xs_reg - xe_reg) : (xe_reg - xs_reg);
        dy     = (ys_reg > ye_reg) ? (ys_reg - ye_reg) : (ye_reg - ys_reg);
        xmaj_s = dx > dy;
        dmaj   = xmaj_s ? dx : dy;
        dmin   = xmaj_s ? dy : dx;
        sa     = xmaj_s ? xs_reg : ys_reg;
        sb     = xmaj_s ? xe_reg : ye_reg;

        // One step along the major axis; minor add is +1 or all ones.
        diag      = !decision_reg[DW-1];
        minor_add = {{(COORD_BITS-1){minor_down_reg}}, 1'b1};

        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        end_major_next    = end_major_reg;
        decision_next     = decision_reg;
        inc_straight_next = inc_straight_reg;
        inc_diagonal_next = inc_diagonal_reg;
        minor_down_next   = minor_down_reg;
        x_major_next      = x_major_reg;
        held_color_next   = held_color_reg;
        has_result        = 1'b0;

        if (op_reg == lrast_pkg::OP_START)
        begin
            has_result        = 1'b1;
            held_color_next   = color_in_reg;
            x_major_next      = xmaj_s;
            if (sa > sb)
            begin
                cur_x_next      = xe_reg;
                cur_y_next      = ye_reg;
                end_major_next  = sa;
                minor_down_next = xmaj_s ? (ys_reg < ye_reg) : (xs_reg < xe_reg);
            end
            else
            begin
                cur_x_next      = xs_reg;
                cur_y_next      = ys_reg;
                end_major_next  = sb;
                minor_down_next = xmaj_s ? (ye_reg < ys_reg) : (xe_reg < xs_reg);
            end
            decision_next     = {2'b00, dmin, 1'b0} - {3'b000, dmaj};
            inc_straight_next = {1'b0, dmin, 1'b0};
            inc_diagonal_next = {2'b00, dmin, 1'b0} - {2'b00, dmaj, 1'b0};
        end
        else if (busy_reg)
        begin
            has_result = 1'b1;
            if (x_major_reg)
            begin
                cur_x_next = cur_x_reg + {{(COORD_BITS-1){1'b0}}, 1'b1};
                if (diag)
                begin
                    cur_y_next = cur_y_reg + minor_add;
                end
            end
            else
            begin
                cur_y_next = cur_y_reg + {{(COORD_BITS-1){1'b0}}, 1'b1};
                if (diag)
                begin
                    cur_x_next = cur_x_reg + minor_add;
                end
            end
            decision_next = decision_reg +
                            (diag ? inc_diagonal_reg : {1'b0, inc_straight_reg});
        end

        major_next = x_major_next ? cur_x_next : cur_y_next;
        fin_next   = (major_next == end_major_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                cmd_valid_reg <= cmd.valid;
            end
            if (step_go)
            begin
                pix_valid_reg <= has_result;
                if (has_result)
                begin
                    busy_reg <= !fin_next;
                end
            end
            else if (stp_ready)
            begin
                pix_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            op_reg       <= cmd.op;
            xs_reg       <= cmd.x_start;
            ys_reg       <= cmd.y_start;
            xe_reg       <= cmd.x_end;
            ye_reg       <= cmd.y_end;
            color_in_reg <= cmd.color;
        end
        if (step_go && has_result)
        begin
            cur_x_reg        <= cur_x_next;
            cur_y_reg        <= cur_y_next;
            end_major_reg    <= end_major_next;
            decision_reg     <= decision_next;
            inc_straight_reg <= inc_straight_next;
            inc_diagonal_reg <= inc_diagonal_next;
            minor_down_reg   <= minor_down_next;
            x_major_reg      <= x_major_next;
            held_color_reg   <= held_color_next;
            pix_x_reg        <= cur_x_next;
            pix_y_reg        <= cur_y_next;
            pix_color_reg    <= held_color_next;
            pix_last_reg     <= fin_next;
        end
    end

    assign stp_valid = pix_valid_reg;
    assign stp_x     = pix_x_reg;
    assign stp_y     = pix_y_reg;
    assign stp_color = pix_color_reg;
    assign stp_last  = pix_last_reg;

endmodule

// ===== rtl/lrast_addr.sv =====
module lrast_addr #(
    parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lrast_pkg::cfg_t                    cfg,
    input  logic                               stp_valid,
    output logic                               stp_ready,
    input  logic [COORD_BITS-1:0]              stp_x,
    input  logic [COORD_BITS-1:0]              stp_y,
    input  logic [lrast_pkg::COLOR_BITS-1:0]   stp_color,
    input  logic                               stp_last,
    lrast_out_if.source                        pix
);

    localparam int PW = lrast_pkg::STRIDE_BITS + COORD_BITS;

    logic                              out_valid_reg;
    logic [COORD_BITS-1:0]             out_x_reg;
    logic [COORD_BITS-1:0]             out_y_reg;
    logic [lrast_pkg::ADDR_BITS-1:0]   out_addr_reg;
    logic [lrast_pkg::COLOR_BITS-1:0]  out_color_reg;
    logic                              out_last_reg;
    logic [PW-1:0]                     row_offset;
    logic [lrast_pkg::ADDR_BITS-1:0]   addr_next;

    assign stp_ready = !out_valid_reg || pix.ready;

    // Row offset fits in 32 bits for coordinate widths up to 19 bits.
    assign row_offset = PW'(cfg.line_stride) * PW'(stp_y);
    assign addr_next  = cfg.frame_base
                      + {{(lrast_pkg::ADDR_BITS - PW){1'b0}}, row_offset}
                      + {{(lrast_pkg::ADDR_BITS - COORD_BITS){1'b0}}, stp_x};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stp_ready)
        begin
            out_valid_reg <= stp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stp_ready && stp_valid)
        begin
            out_x_reg     <= stp_x;
            out_y_reg     <= stp_y;
            out_addr_reg  <= addr_next;
            out_color_reg <= stp_color;
            out_last_reg  <= stp_last;
        end
    end

    assign pix.valid         = out_valid_reg;
    assign pix.pixel_x       = out_x_reg;
    assign pix.pixel_y       = out_y_reg;
    assign pix.pixel_address = out_addr_reg;
    assign pix.pixel_color   = out_color_reg;
    assign pix.last          = out_last_reg;

endmodule

// ===== rtl/line_rasterizer.sv =====
// Bresenham line rasterizer. A start item (op = 0) loads two endpoints and a
// color and yields the first pixel; each next item (op = 1) yields the
// following pixel, with its byte address frame_base + line_stride * y + x
// (modulo 2^32) and a last flag on the final endpoint. Lines are drawn from
// the endpoint with the smaller major coordinate, and a line whose |dx|
// equals |dy| is treated as y-major. A next item while no line is active
// yields nothing, and a start item abandons any line in progress. The block
// takes one item per cycle when the output side is not stalled. An accepted
// item passes from the input register to the step stage, whose single add
// and compare on the error term sets the rate, and from there through the
// address stage, which holds the stride multiply, into the output register.
// Each stage holds its item while the stage after it is full, so the input
// keeps flowing as long as an empty slot remains ahead of it. The stride and
// base registers sit on the APB port at byte addresses 0 and 4 and should be
// written only while no item is in flight.

`include "line_rasterizer_macros.svh"

module line_rasterizer #(
    parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [lrast_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [lrast_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [lrast_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                   pready,
    lrast_in_if.sink                               cmd,
    lrast_out_if.source                            pix
);

    localparam int AW = lrast_pkg::ADDR_BITS;

    // Configuration seen by the address stage.
    lrast_pkg::cfg_t                   cfg;

    // Handoff from the step stage to the address stage.
    logic                              stp_valid;
    logic                              stp_ready;
    logic [COORD_BITS-1:0]             stp_x;
    logic [COORD_BITS-1:0]             stp_y;
    logic [lrast_pkg::COLOR_BITS-1:0]  stp_color;
    logic                              stp_last;

    // Address that the pixel on the output should carry.
    logic [AW-1:0]                     chk_addr;

    // Register file for stride and frame base.
    lrast_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register, line state and one Bresenham step per item.
    lrast_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stp_valid (stp_valid),
        .stp_ready (stp_ready),
        .stp_x     (stp_x),
        .stp_y     (stp_y),
        .stp_color (stp_color),
        .stp_last  (stp_last)
    );

    // Address computation and the output register.
    lrast_addr #(
        .COORD_BITS (COORD_BITS)
    ) u_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .stp_valid (stp_valid),
        .stp_ready (stp_ready),
        .stp_x     (stp_x),
        .stp_y     (stp_y),
        .stp_color (stp_color),
        .stp_last  (stp_last),
        .pix       (pix)
    );

    assign chk_addr = cfg.frame_base
                    + AW'(cfg.line_stride) * AW'(pix.pixel_y)
                    + AW'(pix.pixel_x);

    // A pixel handed to the address stage shows up on the output next cycle.
    `LRAST_ASSERT_NEXT(a_handoff_to_out, clk, rst_n, stp_valid && stp_ready, pix.valid)

    // Every shown pixel carries the address of its coordinates.
    `LRAST_ASSERT_NOW(a_addr_match, clk, rst_n, pix.valid, pix.pixel_address == chk_addr)

    // The address stage never refuses a pixel while the output register is free.
    `LRAST_ASSERT_NOW(a_addr_ready, clk, rst_n, !pix.valid, stp_ready)

endmodule
